[rtl/artc_pkg.sv]
// shared types, register indexes and constants of the altitude rate throttle controller
package artc_pkg;

    // mode carried by each request
    typedef enum logic [1:0] {
        KIND_START   = 2'd0,
        KIND_TAKEOFF = 2'd1,
        KIND_HOVER   = 2'd2,
        KIND_LAND    = 2'd3
    } kind_t;

    // configuration register indexes
    localparam logic [2:0] REG_PROP_GAIN      = 3'd0;
    localparam logic [2:0] REG_INT_GAIN       = 3'd1;
    localparam logic [2:0] REG_THROTTLE_LIMIT = 3'd2;
    localparam logic [2:0] REG_HOVER_THROTTLE = 3'd3;
    localparam logic [2:0] REG_LAND_THROTTLE  = 3'd4;

    // configuration reset values
    localparam logic [7:0] PROP_GAIN_RST      = 8'd5;
    localparam logic [7:0] INT_GAIN_RST       = 8'd0;
    localparam logic [6:0] THROTTLE_LIMIT_RST = 7'd127;
    localparam logic [7:0] HOVER_THROTTLE_RST = 8'd128;
    localparam logic [7:0] LAND_THROTTLE_RST  = 8'd0;

    // safe height band
    localparam logic [11:0] SAFE_HIGH = 12'd200;
    localparam logic [11:0] SAFE_LOW  = 12'd16;

    // fixed descent on the fine throttle
    localparam logic signed [7:0] FINE_LAND = -8'sd127;

    // integral term clamp and the magnitude at which it saturates (33 * 5625)
    localparam logic [5:0]  INT_CLAMP     = 6'd32;
    localparam logic [40:0] INT_SAT_BOUND = 41'd185625;

    // reciprocals: ceil(2^23 / 5), exact for magnitudes below 2^20
    localparam logic [20:0] RECIP5       = 21'd1677722;
    // ceil(2^31 / 5625), exact for magnitudes below 2^18
    localparam logic [18:0] RECIP5625    = 19'd381775;

    // 32-bit saturation limits of the error integral
    localparam logic signed [31:0] SUM_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] SUM_MIN = 32'sh8000_0000;

    // stepped target rate from the height error
    function automatic logic signed [3:0] rate_step(input logic signed [12:0] err);
        logic signed [3:0] step;
        if (err > -13'sd5 && err < 13'sd5) begin
            step = 4'sd0;
        end else if (err > 13'sd0) begin
            if (err < 13'sd10) begin
                step = 4'sd1;
            end else if (err < 13'sd15) begin
                step = 4'sd2;
            end else if (err < 13'sd20) begin
                step = 4'sd3;
            end else begin
                step = 4'sd4;
            end
        end else if (err > -13'sd10) begin
            step = -4'sd1;
        end else if (err > -13'sd15) begin
            step = -4'sd2;
        end else if (err > -13'sd20) begin
            step = -4'sd3;
        end else if (err > -13'sd30) begin
            step = -4'sd4;
        end else begin
            step = -4'sd6;
        end
        return step;
    endfunction

endpackage

[rtl/altitude_rate_throttle_controller_unit.sv]
// top level of the altitude rate throttle controller: history, integral and throttle pipeline
// One request is taken per clock cycle when the pipeline is not stalled, and each gives
// exactly one result after the input register, four stage registers and the output
// register. The rate is set by the first stage, where the distance history, fill count,
// saturating error integral and flight status are updated together; the multiplications
// by the gains and the constant divisions by 5 and 5625 follow in separate registered
// stages. Each stage holds its request until the next one has room, so a stall at m_ready
// backs up the pipeline without losing anything. The user must write the configuration
// registers through cfg_we, cfg_index and cfg_wdata only while idle; the block does not check.
module altitude_rate_throttle_controller_unit #(
    parameter int HISTORY_DEPTH = 5
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration write port
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [7:0]         cfg_wdata,
    // request channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic [11:0]        s_target_height,
    input  logic [11:0]        s_distance,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [7:0]  m_fine_throttle,
    output logic signed [9:0]  m_coarse_throttle,
    output logic               m_flight_status
);

    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);

    // configuration registers
    logic [7:0] prop_gain_reg;
    logic [7:0] int_gain_reg;
    logic [6:0] throttle_limit_reg;
    logic [7:0] hover_throttle_reg;
    logic [7:0] land_throttle_reg;

    // controller state
    logic [11:0]        hist_reg [HISTORY_DEPTH];
    logic [FILL_W-1:0]  fill_count_reg;
    logic signed [31:0] error_sum_reg;
    logic               last_status_reg;

    // pipeline valids and flow control
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, m_valid_reg;
    logic room1, room2, room3, room4, room5, room_out;
    logic go1, go2, go3, go4, go5;

    // stage payloads
    artc_pkg::kind_t    k1_reg, k2_reg, k3_reg, k4_reg, k5_reg;
    logic [11:0]        target1_reg, dist1_reg;
    logic               st2_reg, st3_reg, st4_reg, st5_reg;
    logic signed [13:0] rd2_reg;
    logic signed [31:0] esum2_reg;
    logic signed [22:0] p3_reg;
    logic signed [40:0] q3_reg;
    logic [19:0]        pmag4_reg;
    logic [17:0]        qmag4_reg;
    logic               psign4_reg, qsign4_reg, qsat4_reg;
    logic [17:0]        qp5_reg;
    logic [5:0]         qi5_reg;
    logic               psign5_reg, qsign5_reg;

    // output payload registers, which also serve as the last reported throttles
    logic signed [7:0]  fine_reg;
    logic signed [9:0]  coarse_reg;
    logic               status_reg;

    // ------------------------------------------------------------------
    // handshake: each stage moves when the one after it has room
    // ------------------------------------------------------------------
    assign room_out = !m_valid_reg || m_ready;
    assign go5      = v5_reg && room_out;
    assign room5    = !v5_reg || go5;
    assign go4      = v4_reg && room5;
    assign room4    = !v4_reg || go4;
    assign go3      = v3_reg && room4;
    assign room3    = !v3_reg || go3;
    assign go2      = v2_reg && room3;
    assign room2    = !v2_reg || go2;
    assign go1      = v1_reg && room2;
    assign room1    = !v1_reg || go1;

    assign s_ready  = room1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (room1)    v1_reg      <= s_valid;
            if (room2)    v2_reg      <= go1;
            if (room3)    v3_reg      <= go2;
            if (room4)    v4_reg      <= go3;
            if (room5)    v5_reg      <= go4;
            if (room_out) m_valid_reg <= go5;
        end
    end

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg      <= artc_pkg::PROP_GAIN_RST;
            int_gain_reg       <= artc_pkg::INT_GAIN_RST;
            throttle_limit_reg <= artc_pkg::THROTTLE_LIMIT_RST;
            hover_throttle_reg <= artc_pkg::HOVER_THROTTLE_RST;
            land_throttle_reg  <= artc_pkg::LAND_THROTTLE_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                artc_pkg::REG_PROP_GAIN:      prop_gain_reg      <= cfg_wdata;
                artc_pkg::REG_INT_GAIN:       int_gain_reg       <= cfg_wdata;
                artc_pkg::REG_THROTTLE_LIMIT: throttle_limit_reg <= cfg_wdata[6:0];
                artc_pkg::REG_HOVER_THROTTLE: hover_throttle_reg <= cfg_wdata;
                artc_pkg::REG_LAND_THROTTLE:  land_throttle_reg  <= cfg_wdata;
                default: ;  // unused indexes are ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (room1 && s_valid) begin
            k1_reg      <= artc_pkg::kind_t'(s_kind);
            target1_reg <= s_target_height;
            dist1_reg   <= s_distance;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: history, height error, integral and status
    // ------------------------------------------------------------------
    logic               s1_full, s1_near;
    logic [11:0]        s1_newest;
    logic signed [12:0] s1_diff, s1_err;
    logic signed [32:0] s1_sum_wide;
    logic signed [31:0] s1_sum;
    logic signed [3:0]  s1_step;
    logic signed [13:0] s1_rd;
    logic               s1_in_band, s1_status;

    assign s1_full = (fill_count_reg == FILL_W'(HISTORY_DEPTH));
    assign s1_near = (fill_count_reg >= FILL_W'(HISTORY_DEPTH - 1));

    // newest slot holds zero until the history fills
    assign s1_newest = s1_near ? dist1_reg : hist_reg[HISTORY_DEPTH-1];

    // oldest entry after the shift is the current second entry
    assign s1_diff = s1_full
        ? ($signed({1'b0, dist1_reg}) - $signed({1'b0, hist_reg[1]}))
        : 13'sd0;

    assign s1_err      = $signed({1'b0, target1_reg}) - $signed({1'b0, s1_newest});
    assign s1_sum_wide = {error_sum_reg[31], error_sum_reg} + {{20{s1_err[12]}}, s1_err};

    always_comb begin
        if (s1_sum_wide[32] != s1_sum_wide[31]) begin
            s1_sum = s1_sum_wide[32] ? artc_pkg::SUM_MIN : artc_pkg::SUM_MAX;
        end else begin
            s1_sum = s1_sum_wide[31:0];
        end
    end

    assign s1_step    = artc_pkg::rate_step(s1_err);
    assign s1_rd      = {{10{s1_step[3]}}, s1_step} - {s1_diff[12], s1_diff};
    assign s1_in_band = (dist1_reg <= artc_pkg::SAFE_HIGH) && (dist1_reg >= artc_pkg::SAFE_LOW);

    always_comb begin
        case (k1_reg)
            artc_pkg::KIND_START:   s1_status = 1'b0;
            artc_pkg::KIND_TAKEOFF: s1_status = 1'b1;
            artc_pkg::KIND_HOVER:   s1_status = s1_in_band;
            default:                s1_status = last_status_reg;
        endcase
    end

    // state update, once per request as it leaves stage 1
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_count_reg  <= '0;
            error_sum_reg   <= '0;
            last_status_reg <= 1'b0;
            for (int k = 0; k < HISTORY_DEPTH; k++) begin
                hist_reg[k] <= '0;
            end
        end else if (go1) begin
            last_status_reg <= s1_status;
            if (k1_reg == artc_pkg::KIND_START) begin
                fill_count_reg <= '0;
                error_sum_reg  <= '0;
                for (int k = 0; k < HISTORY_DEPTH; k++) begin
                    hist_reg[k] <= '0;
                end
            end else if (k1_reg == artc_pkg::KIND_HOVER) begin
                error_sum_reg <= s1_sum;
                if (s1_full) begin
                    // shift towards the oldest slot
                    for (int k = 0; k < HISTORY_DEPTH - 1; k++) begin
                        hist_reg[k] <= hist_reg[k+1];
                    end
                    hist_reg[HISTORY_DEPTH-1] <= dist1_reg;
                end else begin
                    fill_count_reg <= fill_count_reg + FILL_W'(1);
                    for (int k = 0; k < HISTORY_DEPTH; k++) begin
                        if (fill_count_reg == FILL_W'(k)) begin
                            hist_reg[k] <= dist1_reg;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (go1) begin
            k2_reg    <= k1_reg;
            st2_reg   <= s1_status;
            rd2_reg   <= s1_rd;
            esum2_reg <= s1_sum;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: gain products
    // ------------------------------------------------------------------
    logic signed [22:0] s2_prod_p;
    logic signed [40:0] s2_prod_q;

    assign s2_prod_p = rd2_reg * $signed({1'b0, prop_gain_reg});
    assign s2_prod_q = esum2_reg * $signed({1'b0, int_gain_reg});

    always_ff @(posedge aclk) begin
        if (go2) begin
            k3_reg  <= k2_reg;
            st3_reg <= st2_reg;
            p3_reg  <= s2_prod_p;
            q3_reg  <= s2_prod_q;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: magnitudes for the truncating divisions
    // ------------------------------------------------------------------
    logic signed [22:0] s3_p_abs;
    logic signed [40:0] s3_q_abs;

    assign s3_p_abs = p3_reg[22] ? -p3_reg : p3_reg;
    assign s3_q_abs = q3_reg[40] ? -q3_reg : q3_reg;

    always_ff @(posedge aclk) begin
        if (go3) begin
            k4_reg     <= k3_reg;
            st4_reg    <= st3_reg;
            pmag4_reg  <= s3_p_abs[19:0];
            psign4_reg <= p3_reg[22];
            qmag4_reg  <= s3_q_abs[17:0];
            qsign4_reg <= q3_reg[40];
            qsat4_reg  <= ($unsigned(s3_q_abs) >= artc_pkg::INT_SAT_BOUND);
        end
    end

    // ------------------------------------------------------------------
    // stage 4: divide by 5 and by 5625 through reciprocals
    // ------------------------------------------------------------------
    logic [40:0] s4_prod5;
    logic [36:0] s4_prodi;

    assign s4_prod5 = pmag4_reg * artc_pkg::RECIP5;
    assign s4_prodi = qmag4_reg * artc_pkg::RECIP5625;

    always_ff @(posedge aclk) begin
        if (go4) begin
            k5_reg     <= k4_reg;
            st5_reg    <= st4_reg;
            qp5_reg    <= s4_prod5[40:23];
            qi5_reg    <= qsat4_reg ? artc_pkg::INT_CLAMP : s4_prodi[36:31];
            psign5_reg <= psign4_reg;
            qsign5_reg <= qsign4_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: clamps, hover offset and mode selection
    // ------------------------------------------------------------------
    logic [6:0]         s5_fmag;
    logic signed [7:0]  s5_fine_hover;
    logic signed [6:0]  s5_big;
    logic signed [9:0]  s5_coarse_hover;
    logic signed [7:0]  s5_fine;
    logic signed [9:0]  s5_coarse;

    assign s5_fmag = (qp5_reg > {11'd0, throttle_limit_reg}) ? throttle_limit_reg : qp5_reg[6:0];
    assign s5_fine_hover = psign5_reg ? -$signed({1'b0, s5_fmag}) : $signed({1'b0, s5_fmag});
    assign s5_big = qsign5_reg ? -$signed({1'b0, qi5_reg}) : $signed({1'b0, qi5_reg});
    assign s5_coarse_hover = {{3{s5_big[6]}}, s5_big} + $signed({2'b00, hover_throttle_reg});

    always_comb begin
        case (k5_reg)
            artc_pkg::KIND_START: begin
                s5_fine   = 8'sd0;
                s5_coarse = 10'sd0;
            end
            artc_pkg::KIND_TAKEOFF: begin
                // throttles repeat their last values
                s5_fine   = fine_reg;
                s5_coarse = coarse_reg;
            end
            artc_pkg::KIND_HOVER: begin
                s5_fine   = s5_fine_hover;
                s5_coarse = s5_coarse_hover;
            end
            default: begin
                s5_fine   = artc_pkg::FINE_LAND;
                s5_coarse = $signed({2'b00, land_throttle_reg});
            end
        endcase
    end

    // output register, reset as the last reported throttles and status
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fine_reg   <= '0;
            coarse_reg <= '0;
            status_reg <= 1'b0;
        end else if (go5) begin
            fine_reg   <= s5_fine;
            coarse_reg <= s5_coarse;
            status_reg <= st5_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_fine_throttle   = fine_reg;
    assign m_coarse_throttle = coarse_reg;
    assign m_flight_status   = status_reg;

`ifndef NO_ASSERTIONS
    // fill count never runs past the history depth
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= FILL_W'(HISTORY_DEPTH))
        else $error("history fill count beyond depth");

    // start clears the integral and the history fill
    a_start_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        go1 && (k1_reg == artc_pkg::KIND_START) |=> (error_sum_reg == 32'sd0)
            && (fill_count_reg == '0) && !last_status_reg)
        else $error("start did not clear controller state");

    // landing gives the fixed descent
    a_land_fine: assert property (@(posedge aclk) disable iff (!aresetn)
        go5 && (k5_reg == artc_pkg::KIND_LAND) |=> (m_fine_throttle == artc_pkg::FINE_LAND))
        else $error("land result without fixed descent");

    // hover fine throttle stays inside the configured limit
    a_hover_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        go5 && (k5_reg == artc_pkg::KIND_HOVER) |=>
            (m_fine_throttle <= $signed({1'b0, throttle_limit_reg}))
            && (m_fine_throttle >= -$signed({1'b0, throttle_limit_reg})))
        else $error("fine throttle outside limit");

    // coarse throttle stays inside its range
    a_coarse_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_coarse_throttle >= -10'sd32) && (m_coarse_throttle <= 10'sd287))
        else $error("coarse throttle out of range");
`endif

endmodule
